FILE: hdl/ptts_pkg.sv
// Shared widths, codes and defaults for the periodic task tick scheduler.
package ptts_pkg;

	localparam int unsigned MAX_TASKS_DEF   = 16;
	localparam int unsigned ACT_W           = 2;
	localparam int unsigned ID_W            = 32;
	localparam int unsigned PER_W           = 32;
	localparam int unsigned RES_W           = 3;
	localparam int unsigned TOT_W           = 5;
	localparam int unsigned ENT_W           = ID_W + 2 * PER_W;
	localparam int unsigned S_DATA_W        = 64;
	localparam int unsigned M_DATA_W        = 40;
	localparam logic [PER_W-1:0] TICK_PERIOD_RST = 32'd1000;

	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

	localparam logic [RES_W-1:0] EV_TICK    = 3'd0;
	localparam logic [RES_W-1:0] EV_FIRED   = 3'd1;
	localparam logic [RES_W-1:0] EV_ADDED   = 3'd2;
	localparam logic [RES_W-1:0] EV_REJECT  = 3'd3;
	localparam logic [RES_W-1:0] EV_REMOVED = 3'd4;
	localparam logic [RES_W-1:0] EV_MISSING = 3'd5;
	localparam logic [RES_W-1:0] EV_CLEARED = 3'd6;

	typedef struct packed {
		logic [PER_W-1:0] elapsed;
		logic [PER_W-1:0] period;
		logic [ID_W-1:0]  id;
	} entry_t;

endpackage

FILE: hdl/periodic_task_tick_scheduler_unit.sv
// Periodic task tick scheduler: task table in RAM walked by a read-modify-write sequencer.
//
//  Channel | Signals                            | Contents (low bit first)
//  --------+------------------------------------+-----------------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser  | tdata: task_id, task_period; tuser: action
//  m_      | m_tvalid m_tready m_tdata m_tuser  | tdata: event_task_id, task_total; tuser:
//          | m_tlast                            |   event_res; tlast: last
//  cfg_    | cfg_we cfg_wdata                   | tick_period_us
//
// A tick, an add or a remove on a table of n entries walks all n entries, one RAM read a
// cycle while the walk is not stalled, and the final result then enters the output register;
// the next request is taken after that. Any request on an empty table, a clear and a rejected
// add skip the walk. Reset empties the table at once. A tick stalls its walk while
// a second fire request waits for the output register, and every request holds in its final
// state until the output register is free.
module periodic_task_tick_scheduler_unit #(
	parameter int unsigned MAX_TASKS = ptts_pkg::MAX_TASKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ptts_pkg::S_DATA_W-1:0]   s_tdata,  // task_id, task_period
	input  logic [ptts_pkg::ACT_W-1:0]      s_tuser,  // action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ptts_pkg::M_DATA_W-1:0]   m_tdata,  // event_task_id, task_total, zero pad
	output logic [ptts_pkg::RES_W-1:0]      m_tuser,  // event_res
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [ptts_pkg::PER_W-1:0]      cfg_wdata
);
	import ptts_pkg::*;

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t           state_q;
	logic [PER_W-1:0] tick_period_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_q;
	logic [CNT_W-1:0] rem_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic             reject_q;
	logic             pend_v_q;
	logic [ID_W-1:0]  pend_id_q;
	logic [ACT_W-1:0] op_q;
	logic [ID_W-1:0]  id_q;
	logic [PER_W-1:0] per_q;

	logic             out_v_q;
	logic [RES_W-1:0] out_res_q;
	logic [ID_W-1:0]  out_id_q;
	logic [TOT_W-1:0] out_tot_q;
	logic             out_last_q;

	entry_t           rd_ent;
	entry_t           wr_ent;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;

	logic [PER_W:0]   tick_sum;
	logic [PER_W-1:0] tick_sat;
	logic             fire;
	logic             match;
	logic             out_free;
	logic             stall;
	logic             issue;
	logic             proc;
	logic             push_walk;
	logic             accept;
	logic             fin_go;
	logic [RES_W-1:0] fin_res;
	logic [ID_W-1:0]  fin_id;
	logic [CNT_W-1:0] fin_cnt;

	ptts_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_ent),
		.raddr(ram_raddr),
		.rdata(rd_ent)
	);

	assign tick_sum  = {1'b0, rd_ent.elapsed} + {1'b0, tick_period_q};
	assign tick_sat  = tick_sum[PER_W] ? '1 : tick_sum[PER_W-1:0];
	assign fire      = (tick_sat >= rd_ent.period);
	assign match     = (id_q != '0) && (rd_ent.id == id_q);
	assign out_free  = !out_v_q || m_tready;
	assign stall     = valid_s1 && (op_q == ACT_TICK) && fire && pend_v_q && !out_free;
	assign issue     = (state_q == ST_WALK) && (rem_q != '0) && !stall;
	assign proc      = (state_q == ST_WALK) && valid_s1 && !stall;
	assign push_walk = proc && (op_q == ACT_TICK) && fire && pend_v_q;
	assign accept    = s_tvalid && s_tready;
	assign fin_go    = (state_q == ST_FIN) && out_free;
	assign ram_raddr = stall ? idx_s1 : rd_q[IDX_W-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		wr_ent    = rd_ent;
		if (proc) begin
			unique case (op_q)
				ACT_TICK: begin
					ram_we         = 1'b1;
					wr_ent.elapsed = fire ? '0 : tick_sat;
				end
				ACT_ADD: begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 + IDX_W'(1);
				end
				ACT_REMOVE: begin
					ram_we    = found_q;
					ram_waddr = idx_s1 - IDX_W'(1);
				end
				ACT_CLEAR: begin
					ram_we = 1'b0;
				end
			endcase
		end else if (fin_go && (op_q == ACT_ADD) && !reject_q) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			wr_ent    = '{elapsed: '0, period: per_q, id: id_q};
		end
	end

	always_comb begin
		fin_res = EV_TICK;
		fin_id  = '0;
		fin_cnt = cnt_q;
		unique case (op_q)
			ACT_TICK: begin
				if (pend_v_q) begin
					fin_res = EV_FIRED;
					fin_id  = pend_id_q;
				end
			end
			ACT_ADD: begin
				if (reject_q) begin
					fin_res = EV_REJECT;
				end else begin
					fin_res = EV_ADDED;
					fin_id  = id_q;
					fin_cnt = cnt_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (found_q) begin
					fin_res = EV_REMOVED;
					fin_id  = id_q;
					fin_cnt = cnt_q - CNT_W'(1);
				end else begin
					fin_res = EV_MISSING;
				end
			end
			ACT_CLEAR: begin
				fin_res = EV_CLEARED;
				fin_cnt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tick_period_q <= TICK_PERIOD_RST;
			cnt_q         <= '0;
			rem_q         <= '0;
			valid_s1      <= 1'b0;
			found_q       <= 1'b0;
			pend_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_period_q <= cfg_wdata;
			end
			if (out_free) begin
				out_v_q <= push_walk || fin_go;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						rem_q    <= cnt_q;
						if ((s_tuser == ACT_CLEAR) || (cnt_q == '0) ||
						    ((s_tuser == ACT_ADD) &&
						     ((s_tdata[ID_W-1:0] == '0) || (cnt_q == CNT_MAX)))) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (!stall) begin
						valid_s1 <= issue;
						if (issue) begin
							rem_q <= rem_q - CNT_W'(1);
						end
					end
					if (proc && (op_q == ACT_REMOVE) && !found_q && match) begin
						found_q <= 1'b1;
					end
					if (proc && (op_q == ACT_TICK) && fire) begin
						pend_v_q <= 1'b1;
					end
					if ((rem_q == '0) && !valid_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						cnt_q    <= fin_cnt;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= s_tuser;
			id_q     <= s_tdata[ID_W-1:0];
			per_q    <= s_tdata[ID_W +: PER_W];
			reject_q <= (s_tuser == ACT_ADD) &&
			            ((s_tdata[ID_W-1:0] == '0) || (cnt_q == CNT_MAX));
			rd_q     <= (s_tuser == ACT_ADD) ? (cnt_q - CNT_W'(1)) : '0;
		end else if (issue) begin
			rd_q <= (op_q == ACT_ADD) ? (rd_q - CNT_W'(1)) : (rd_q + CNT_W'(1));
		end
		if (issue) begin
			idx_s1 <= rd_q[IDX_W-1:0];
		end
		if (proc && (op_q == ACT_TICK) && fire) begin
			pend_id_q <= rd_ent.id;
		end
		if (push_walk) begin
			out_res_q  <= EV_FIRED;
			out_id_q   <= pend_id_q;
			out_tot_q  <= TOT_W'(cnt_q);
			out_last_q <= 1'b0;
		end else if (fin_go) begin
			out_res_q  <= fin_res;
			out_id_q   <= fin_id;
			out_tot_q  <= TOT_W'(fin_cnt);
			out_last_q <= 1'b1;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tuser  = out_res_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(M_DATA_W - ID_W - TOT_W)'(0), out_tot_q, out_id_q};

endmodule

FILE: hdl/ptts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ptts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
